// File: rtl/core/pwtc_pkg.sv
// Package for the pulse-width time-code decoder.
// Holds the phase, command and symbol codes, pulse windows and the result struct.
// No dependencies.
package pwtc_pkg;

  // Widths fixed by the item fields.
  localparam int unsigned ElapsedW = 16;
  localparam int unsigned SymbolW  = 3;
  localparam int unsigned PosW     = 5;
  localparam int unsigned PhaseW   = 2;

  // Phase codes of the decode machine.
  localparam logic [PhaseW-1:0] PH_WAIT_FALL = 2'd0;
  localparam logic [PhaseW-1:0] PH_LOW_PULSE = 2'd1;
  localparam logic [PhaseW-1:0] PH_HIGH_GAP  = 2'd2;

  // Command codes on the func field.
  localparam logic FUNC_EDGE = 1'b0;
  localparam logic FUNC_ARM  = 1'b1;

  // Frame marker symbol.
  localparam logic [SymbolW-1:0] SYM_MARKER = 3'd4;

  // Pulse windows in ticks; both bounds are exclusive.
  localparam logic [ElapsedW-1:0] WIN0_LO = 16'd3250;
  localparam logic [ElapsedW-1:0] WIN0_HI = 16'd3290;
  localparam logic [ElapsedW-1:0] WIN1_LO = 16'd6530;
  localparam logic [ElapsedW-1:0] WIN1_HI = 16'd6580;
  localparam logic [ElapsedW-1:0] WIN2_LO = 16'd9810;
  localparam logic [ElapsedW-1:0] WIN2_HI = 16'd9850;
  localparam logic [ElapsedW-1:0] WIN3_LO = 16'd13080;
  localparam logic [ElapsedW-1:0] WIN3_HI = 16'd13130;

  // A high gap longer than this is a frame marker.
  localparam logic [ElapsedW-1:0] GAP_MARK_TICKS = 16'd32768;

  // One decoded result, passed from the decode logic to the output register.
  typedef struct packed {
    logic                valid;
    logic [SymbolW-1:0]  symbol;
    logic [PosW-1:0]     position;
    logic                frame_done;
    logic [PosW-1:0]     marker_position;
  } result_t;

endpackage

// File: rtl/core/pwtc_classify.sv
// Pulse and gap classifier for the time-code decoder.
// Compares a tick count against the four pulse windows and the marker threshold.
// Depends on pwtc_pkg.
module pwtc_classify (
  input  logic [pwtc_pkg::ElapsedW-1:0] elapsed_i,
  output logic                          hit_o,
  output logic [1:0]                    class_o,
  output logic                          gap_mark_o
);

  logic in_win0;
  logic in_win1;
  logic in_win2;
  logic in_win3;

  // Window compares, all bounds exclusive.
  assign in_win0 = (elapsed_i > pwtc_pkg::WIN0_LO) && (elapsed_i < pwtc_pkg::WIN0_HI);
  assign in_win1 = (elapsed_i > pwtc_pkg::WIN1_LO) && (elapsed_i < pwtc_pkg::WIN1_HI);
  assign in_win2 = (elapsed_i > pwtc_pkg::WIN2_LO) && (elapsed_i < pwtc_pkg::WIN2_HI);
  assign in_win3 = (elapsed_i > pwtc_pkg::WIN3_LO) && (elapsed_i < pwtc_pkg::WIN3_HI);

  // The windows do not overlap, so a plain priority encode is enough.
  always_comb begin
    hit_o   = 1'b1;
    class_o = 2'd0;
    if (in_win0) begin
      class_o = 2'd0;
    end else if (in_win1) begin
      class_o = 2'd1;
    end else if (in_win2) begin
      class_o = 2'd2;
    end else if (in_win3) begin
      class_o = 2'd3;
    end else begin
      hit_o = 1'b0;
    end
  end

  // A gap strictly longer than the marker threshold marks the frame.
  assign gap_mark_o = elapsed_i > pwtc_pkg::GAP_MARK_TICKS;

endmodule

// File: rtl/core/pwtc_fsm.sv
// Decode state machine of the time-code decoder.
// Holds phase, symbol count, marker index and arm flag; builds one result per event.
// Depends on pwtc_pkg and pwtc_classify.
module pwtc_fsm #(
  parameter int unsigned FRAME_LEN = 21
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  logic                          func_i,
  input  logic                          level_i,
  input  logic [pwtc_pkg::ElapsedW-1:0] elapsed_i,
  output pwtc_pkg::result_t             result_o
);

  localparam logic [pwtc_pkg::PosW-1:0] FrameLast = pwtc_pkg::PosW'(FRAME_LEN - 1);

  logic [pwtc_pkg::PhaseW-1:0]  phase_q, phase_d;
  logic [pwtc_pkg::PosW-1:0]    count_q, count_d;
  logic [pwtc_pkg::PosW-1:0]    marker_q, marker_d;
  logic                         armed_q, armed_d;

  logic                         hit;
  logic [1:0]                   pulse_class;
  logic                         gap_mark;
  logic                         emit;
  logic [pwtc_pkg::SymbolW-1:0] emit_sym;
  logic                         last;

  pwtc_classify u_classify (
    .elapsed_i  (elapsed_i),
    .hit_o      (hit),
    .class_o    (pulse_class),
    .gap_mark_o (gap_mark)
  );

  assign last = (count_q == FrameLast);

  // Next-state and result logic for one transaction.
  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    marker_d = marker_q;
    armed_d  = armed_q;
    emit     = 1'b0;
    emit_sym = pwtc_pkg::SYM_MARKER;

    if (fire_i) begin
      if (func_i == pwtc_pkg::FUNC_ARM) begin
        armed_d = 1'b1;
      end else if (armed_q) begin
        case (phase_q)
          pwtc_pkg::PH_WAIT_FALL: begin
            if (!level_i) begin
              phase_d = pwtc_pkg::PH_LOW_PULSE;
            end
          end
          pwtc_pkg::PH_LOW_PULSE: begin
            if (level_i) begin
              phase_d  = pwtc_pkg::PH_HIGH_GAP;
              emit     = hit;
              emit_sym = {1'b0, pulse_class};
            end
          end
          pwtc_pkg::PH_HIGH_GAP: begin
            if (!level_i) begin
              phase_d = pwtc_pkg::PH_LOW_PULSE;
              if (gap_mark) begin
                marker_d = count_q;
                emit     = 1'b1;
                emit_sym = pwtc_pkg::SYM_MARKER;
              end
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase

        // A stored symbol advances the count and may close the frame.
        if (emit) begin
          if (last) begin
            count_d = '0;
            phase_d = pwtc_pkg::PH_WAIT_FALL;
            armed_d = 1'b0;
          end else begin
            count_d = count_q + 1'b1;
          end
        end
      end
    end
  end

  // Result fields; the marker position reflects a marker stored by this event.
  always_comb begin
    result_o.valid           = emit;
    result_o.symbol          = emit_sym;
    result_o.position        = count_q;
    result_o.frame_done      = last;
    result_o.marker_position = marker_d;
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= pwtc_pkg::PH_WAIT_FALL;
      count_q  <= '0;
      marker_q <= '0;
      armed_q  <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      marker_q <= marker_d;
      armed_q  <= armed_d;
    end
  end

endmodule

// File: rtl/core/pulse_width_time_code_decoder_core.sv
// Top level of the pulse-width time-code decoder.
// Holds the input register and output register around pwtc_fsm.
// Depends on pwtc_pkg and pwtc_fsm.
//
// Usage:
// Each input transaction is either an edge event (func 0) with the line level
// after the edge and the tick count since the previous edge, or an arm command
// (func 1). Edge events are ignored until the decoder is armed. Each decoded
// pulse or frame marker leaves as one output transaction carrying the symbol,
// its position in the frame, a frame-done flag and the latest marker position.
// Events that decode to nothing produce no output transaction. After the last
// symbol of a frame the decoder disarms and waits for the next arm command.
//
// An accepted transaction is registered in the input register and decoded from
// there; its result is loaded into the output register when the decode stage
// moves on, and out_valid_o rises with it. One transaction can be accepted
// every cycle while the receiver does not stall; the rate is set by the single
// decode stage between the input register and the output register.
// Reset clears the phase, symbol count, marker index and arm flag, and empties
// both registers. When the receiver stalls, the output register holds its
// result, one more transaction waits in the input register, and in_ready_o drops.
module pulse_width_time_code_decoder_core #(
  parameter int unsigned FRAME_LEN = 21
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic                          level_i,
  input  logic [pwtc_pkg::ElapsedW-1:0] elapsed_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pwtc_pkg::SymbolW-1:0]  symbol_o,
  output logic [pwtc_pkg::PosW-1:0]     position_o,
  output logic                          frame_done_o,
  output logic [pwtc_pkg::PosW-1:0]     marker_position_o
);

  logic                          in_valid_q;
  logic                          func_q;
  logic                          level_q;
  logic [pwtc_pkg::ElapsedW-1:0] elapsed_q;
  logic                          advance;
  logic                          in_fire;
  pwtc_pkg::result_t             result;
  pwtc_pkg::result_t             out_q;
  logic                          out_valid_q;

  // The decode stage moves on whenever the output register is free or being taken.
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q    <= func_i;
      level_q   <= level_i;
      elapsed_q <= elapsed_i;
    end
  end

  pwtc_fsm #(
    .FRAME_LEN (FRAME_LEN)
  ) u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (in_valid_q && advance),
    .func_i    (func_q),
    .level_i   (level_q),
    .elapsed_i (elapsed_q),
    .result_o  (result)
  );

  // Output register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q && result.valid;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && result.valid) begin
      out_q <= result;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign symbol_o          = out_q.symbol;
  assign position_o        = out_q.position;
  assign frame_done_o      = out_q.frame_done;
  assign marker_position_o = out_q.marker_position;

endmodule

// File: rtl/core/pwtc_checker.sv
// Port-level checker for the pulse-width time-code decoder.
// Watches the top level's ports only; bound to the top level below.
// Depends on pwtc_pkg.
module pwtc_checker #(
  parameter int unsigned FRAME_LEN = 21
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          func_i,
  input logic                          level_i,
  input logic [pwtc_pkg::ElapsedW-1:0] elapsed_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [pwtc_pkg::SymbolW-1:0]  symbol_o,
  input logic [pwtc_pkg::PosW-1:0]     position_o,
  input logic                          frame_done_o,
  input logic [pwtc_pkg::PosW-1:0]     marker_position_o
);

  localparam logic [pwtc_pkg::PosW-1:0] FrameLast = pwtc_pkg::PosW'(FRAME_LEN - 1);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(symbol_o)
      && $stable(position_o) && $stable(frame_done_o))
    else $error("Stalled result changed.");

  // The frame-done flag comes exactly with the last position of a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frame_done_o == (position_o == FrameLast)))
    else $error("Frame done does not match the last position.");

  // A frame marker records its own position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && symbol_o == pwtc_pkg::SYM_MARKER |-> marker_position_o == position_o)
    else $error("Marker position differs from marker symbol position.");

  // Symbols stay within the defined codes and positions within the frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> symbol_o <= pwtc_pkg::SYM_MARKER && position_o <= FrameLast)
    else $error("Symbol or position out of range.");

  // With the output register free, the block takes a new transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("Input stalled while the output is empty.");

endmodule

bind pulse_width_time_code_decoder_core pwtc_checker #(
  .FRAME_LEN (FRAME_LEN)
) u_pwtc_checker (.*);
